### sv/ttsc_pkg.sv
// ----------------------------------------------------------------------------
// ttsc_pkg
// Shared types and constants of the tempo tick/sample converter.
// ----------------------------------------------------------------------------
package ttsc_pkg;

   localparam int unsigned VALUE_W       = 48;
   localparam int unsigned REG_W         = 20;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned PPQ_W         = 16;
   localparam int unsigned MUL_W         = 40;
   localparam int unsigned PROD_W        = VALUE_W + MUL_W;
   localparam int unsigned DEN_W         = 40;
   localparam int unsigned CSR_ADDR_W    = 1;
   localparam int unsigned QUEUE_DEPTH   = 2;
   localparam int unsigned DEF_TICKS_PER_QUARTER = 960;

   localparam logic [REG_W-1:0] TEMPO_RESET = 20'd120000;
   localparam logic [REG_W-1:0] RATE_RESET  = 20'd48000;
   localparam logic [15:0]      MS_PER_MINUTE = 16'd60000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TEMPO = 1'b0,
      CSR_RATE  = 1'b1
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_CFG   = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef enum logic {
      CMD_TICKS_TO_SAMPLES = 1'b0,
      CMD_SAMPLES_TO_TICKS = 1'b1
   } command_type;

   // Classified job handed from front to back
   typedef struct packed {
      logic               bad_cfg;
      logic               neg;
      logic [VALUE_W-1:0] mag;
      logic [MUL_W-1:0]   mulv;
      logic [DEN_W-1:0]   den;
   } job_type;

endpackage

### sv/tempo_tick_sample_converter.sv
// ----------------------------------------------------------------------------
// tempo_tick_sample_converter
// Converts tick counts to sample indexes and back at the set tempo and rate.
// ----------------------------------------------------------------------------
// Each request passes the front stage and the queue, then the back end: an
// accept state, a multiply state, 22 digit steps of 4 bits (skipped on a bad
// configuration) and a finish state. The front and a two-entry queue keep
// taking requests while the divider works, so requests can arrive back to
// back until the queue fills. The shared divider takes a new request only
// once it is through with the last one; a stalled response holds the back
// end in its finish state.
module tempo_tick_sample_converter #(
   parameter int unsigned TICKS_PER_QUARTER = ttsc_pkg::DEF_TICKS_PER_QUARTER
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // value_in
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // value_out
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [19:0] csr_data
);
   import ttsc_pkg::*;

   logic [REG_W-1:0] tempo_ff, rate_ff;
   logic             fj_valid, fj_ready, bj_valid, bj_ready;
   job_type          fj, bj;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ff <= TEMPO_RESET;
         rate_ff  <= RATE_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TEMPO: tempo_ff <= csr_data;
            CSR_RATE:  rate_ff  <= csr_data;
            default:   ;
         endcase
      end
   end

   ttsc_front #(.TICKS_PER_QUARTER(TICKS_PER_QUARTER)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_command(req_tuser), .in_value(req_tdata),
      .tempo(tempo_ff), .rate(rate_ff),
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
   );

   ttsc_queue u_queue (
      .clock, .reset,
      .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
      .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
   );

   ttsc_back u_back (
      .clock, .reset,
      .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_value(rsp_tdata), .out_status(rsp_tuser)
   );

endmodule

### sv/ttsc_front.sv
// ----------------------------------------------------------------------------
// ttsc_front
// Accepts requests, takes magnitudes and forms multiplier and divisor.
// ----------------------------------------------------------------------------
module ttsc_front #(
   parameter int unsigned TICKS_PER_QUARTER = ttsc_pkg::DEF_TICKS_PER_QUARTER
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_command,
   input  logic [ttsc_pkg::VALUE_W-1:0] in_value,
   input  logic [ttsc_pkg::REG_W-1:0]   tempo,
   input  logic [ttsc_pkg::REG_W-1:0]   rate,
   output logic                         job_valid,
   input  logic                         job_ready,
   output ttsc_pkg::job_type            job
);
   import ttsc_pkg::*;

   localparam logic [PPQ_W-1:0] PPQ = PPQ_W'(TICKS_PER_QUARTER);

   logic                valid_ff, valid_in;
   logic                cmd_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [DEN_W-1:0]    rate_ms_ff, tempo_ppq_ff;
   logic                bad_ff;
   logic                neg;
   logic [VALUE_W-1:0]  mag;

   assign in_ready = !valid_ff || job_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // register request and the two products of the configuration
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         cmd_ff       <= in_command;
         value_ff     <= in_value;
         rate_ms_ff   <= DEN_W'(rate) * DEN_W'(MS_PER_MINUTE);
         tempo_ppq_ff <= DEN_W'(tempo) * DEN_W'(PPQ);
         bad_ff       <= (tempo == '0) || (rate == '0);
      end
   end

   always_comb begin
      neg = value_ff[VALUE_W-1];
      mag = neg ? (~value_ff + 1'b1) : value_ff;
      if (cmd_ff == CMD_SAMPLES_TO_TICKS && neg) begin
         neg = 1'b0;
         mag = '0;
      end
   end

   assign job_valid   = valid_ff;
   assign job.bad_cfg = bad_ff;
   assign job.neg     = neg;
   assign job.mag     = mag;
   assign job.mulv    = (cmd_ff == CMD_TICKS_TO_SAMPLES) ? rate_ms_ff : tempo_ppq_ff;
   assign job.den     = (cmd_ff == CMD_TICKS_TO_SAMPLES) ? tempo_ppq_ff : rate_ms_ff;

endmodule

### sv/ttsc_queue.sv
// ----------------------------------------------------------------------------
// ttsc_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module ttsc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  ttsc_pkg::job_type wr_job,
   output logic              rd_valid,
   input  logic              rd_ready,
   output ttsc_pkg::job_type rd_job
);
   import ttsc_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   job_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]     count_ff;
   logic               push, pop;

   assign wr_ready = count_ff != (PTR_W+1)'(QUEUE_DEPTH);
   assign rd_valid = count_ff != '0;
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_job   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      end
   end

endmodule

### sv/ttsc_back.sv
// ----------------------------------------------------------------------------
// ttsc_back
// Multiplies, divides with rounding and saturates one job.
// ----------------------------------------------------------------------------
module ttsc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   output logic                         job_ready,
   input  ttsc_pkg::job_type            job,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [ttsc_pkg::VALUE_W-1:0] out_value,
   output logic [ttsc_pkg::STATUS_W-1:0] out_status
);
   import ttsc_pkg::*;

   localparam int unsigned HALF_W   = VALUE_W / 2;
   localparam int unsigned MHALF_W  = MUL_W / 2;
   localparam int unsigned DBITS    = 4;
   localparam int unsigned DSTEPS   = PROD_W / DBITS;
   localparam int unsigned CNT_W    = $clog2(DSTEPS + 1);
   localparam int unsigned REM_W    = DEN_W + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic                 neg_ff, bad_ff;
   logic [VALUE_W-1:0]   mag_ff;
   logic [MUL_W-1:0]     mulv_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [PROD_W-1:0]    pp_ff [4];
   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 ov_valid_ff;
   logic [VALUE_W-1:0]   ov_value_ff, value_in;
   logic [STATUS_W-1:0]  ov_status_ff, status_in;
   logic                 take, finish;
   logic [PROD_W:0]      rounded;

   assign take      = job_valid && job_ready;
   assign out_valid = ov_valid_ff;
   assign out_value = ov_value_ff;
   assign out_status = ov_status_ff;
   assign finish    = (state_ff == ST_DONE) && (!ov_valid_ff || out_ready);
   assign job_ready = state_ff == ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ov_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) ov_valid_ff <= 1'b1;
         else if (out_ready) ov_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (job_valid) state_in = ST_MUL;
         ST_MUL:  state_in = bad_ff ? ST_DONE : ST_DIV;
         ST_DIV:  if (cnt_ff == CNT_W'(DSTEPS - 1)) state_in = ST_DONE;
         ST_DONE: if (finish) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // radix-2 restoring division, DBITS quotient bits per cycle
   always_comb begin
      logic [REM_W-1:0] r;
      logic [PROD_W-1:0] q;
      logic [PROD_W-1:0] prod;
      r = REM_W'(rem_ff);
      q = quo_ff;
      prod = pp_ff[0] + pp_ff[1] + pp_ff[2] + pp_ff[3];
      if (cnt_ff == '0) begin
         q = prod;
         r = '0;
      end
      for (int i = 0; i < DBITS; i++) begin
         r = {r[REM_W-2:0], q[PROD_W-1]};
         q = {q[PROD_W-2:0], 1'b0};
         if (r >= REM_W'(den_ff)) begin
            r = r - REM_W'(den_ff);
            q[0] = 1'b1;
         end
      end
      quo_in = q;
      rem_in = r[DEN_W-1:0];
   end

   assign rounded = {1'b0, quo_ff} +
      (PROD_W+1)'(({1'b0, rem_ff} << 1) >= {1'b0, den_ff});

   always_comb begin
      value_in  = '0;
      status_in = STATUS_OK;
      if (bad_ff) begin
         status_in = STATUS_BAD_CFG;
      end else if (neg_ff) begin
         if (rounded > (PROD_W+1)'({1'b1, {(VALUE_W-1){1'b0}}})) begin
            value_in  = {1'b1, {(VALUE_W-1){1'b0}}};
            status_in = STATUS_SATURATED;
         end else begin
            value_in = ~rounded[VALUE_W-1:0] + 1'b1;
         end
      end else if (rounded > (PROD_W+1)'({1'b0, {(VALUE_W-1){1'b1}}})) begin
         value_in  = {1'b0, {(VALUE_W-1){1'b1}}};
         status_in = STATUS_SATURATED;
      end else begin
         value_in = rounded[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         neg_ff  <= job.neg;
         bad_ff  <= job.bad_cfg;
         mag_ff  <= job.mag;
         mulv_ff <= job.mulv;
         den_ff  <= job.den;
      end
      if (state_ff == ST_MUL) begin
         pp_ff[0] <= PROD_W'(mag_ff[HALF_W-1:0] * mulv_ff[MHALF_W-1:0]);
         pp_ff[1] <= PROD_W'(mag_ff[HALF_W-1:0] * mulv_ff[MUL_W-1:MHALF_W]) << MHALF_W;
         pp_ff[2] <= PROD_W'(mag_ff[VALUE_W-1:HALF_W] * mulv_ff[MHALF_W-1:0]) << HALF_W;
         pp_ff[3] <= PROD_W'(mag_ff[VALUE_W-1:HALF_W] * mulv_ff[MUL_W-1:MHALF_W])
                     << (HALF_W + MHALF_W);
         cnt_ff   <= '0;
      end
      if (state_ff == ST_DIV) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (finish) begin
         ov_value_ff  <= value_in;
         ov_status_ff <= status_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> !bad_ff)
      else $error("division started on bad configuration");
   assert property (@(posedge clock) disable iff (reset)
      finish |=> out_valid)
      else $error("finished job not presented");
   assert property (@(posedge clock) disable iff (reset)
      take |=> state_ff == ST_MUL)
      else $error("accepted job did not start");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tempo tick/sample converter. Conversions in both
// directions are sent over many tempo and rate settings (zero, maximum and
// exact-half cases included), predicted with wide integer arithmetic, and
// every response is compared in order against the predicted value and status.
// ----------------------------------------------------------------------------
module tb;
   import ttsc_pkg::*;

   localparam int unsigned PPQ = DEF_TICKS_PER_QUARTER;

   typedef struct {
      logic [VALUE_W-1:0] value;
      status_type         status;
   } conversion_type;

   class conversion_scoreboard;
      conversion_type     pending_q[$];
      logic [REG_W-1:0]   tempo;
      logic [REG_W-1:0]   rate;
      int                 errors;
      int                 checked;

      function new();
         tempo = TEMPO_RESET;
         rate = RATE_RESET;
         errors = 0;
         checked = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [REG_W-1:0] data);
         if (idx == CSR_TEMPO) tempo = data;
         else rate = data;
      endfunction

      function void note_request(command_type cmd, logic [VALUE_W-1:0] v);
         logic [127:0]   mag, mulv, den, prod, quo, rem, limit;
         bit             neg;
         conversion_type c;
         neg = v[VALUE_W-1];
         mag = {80'd0, neg ? (~v + 48'd1) : v};
         if (tempo == 0 || rate == 0) begin
            c.value = '0;
            c.status = STATUS_BAD_CFG;
            pending_q.push_back(c);
            return;
         end
         if (cmd == CMD_TICKS_TO_SAMPLES) begin
            mulv = 128'(MS_PER_MINUTE) * 128'(rate);
            den = 128'(PPQ) * 128'(tempo);
         end else begin
            if (neg) begin
               mag = '0;
               neg = 0;
            end
            mulv = 128'(tempo) * 128'(PPQ);
            den = 128'(MS_PER_MINUTE) * 128'(rate);
         end
         prod = mag * mulv;
         quo = prod / den;
         rem = prod % den;
         if (rem >= den - rem) quo = quo + 1;
         limit = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
         if (quo > limit) begin
            c.value = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
            c.status = STATUS_SATURATED;
         end else begin
            c.value = neg ? (48'd0 - quo[47:0]) : quo[47:0];
            c.status = STATUS_OK;
         end
         pending_q.push_back(c);
      endfunction

      function void check_response(logic [VALUE_W-1:0] v, logic [STATUS_W-1:0] s);
         conversion_type c;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response value=%h status=%0d", v, s);
            return;
         end
         c = pending_q.pop_front();
         checked++;
         if (v !== c.value || s !== c.status) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                        c.value, c.status, v, s);
         end
      endfunction
   endclass

   logic                clock = 0;
   logic                reset = 1;
   logic                req_tvalid = 0;
   logic                req_tready;
   logic [47:0]         req_tdata = '0;
   logic                req_tuser = 0;
   logic                rsp_tvalid;
   logic                rsp_tready = 0;
   logic [47:0]         rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                csr_valid = 0;
   logic                csr_ready;
   logic                csr_index = 0;
   logic [19:0]         csr_data = '0;

   conversion_scoreboard sb = new();
   bit                   idling = 1;
   int                   stall_left = 0;
   int                   sent = 0;
   int                   cfg_count = 0;

   tempo_tick_sample_converter u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(command_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   task automatic send_request(command_type cmd, logic [47:0] v);
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= v;
      do @(posedge clock); while (!req_tready);
      sent++;
      if (idling && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [19:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.write_reg(idx, data);
      cfg_count++;
      @(posedge clock);
   endtask

   function automatic logic [47:0] random_value();
      logic [47:0] v;
      case ($urandom_range(0, 5))
         0: v = 48'({$urandom, $urandom});
         1: v = 48'($signed($urandom_range(0, 4000)) - 2000);
         2: v = 48'($signed($urandom));
         3: v = 48'($urandom_range(0, 50_000_000));
         4: v = $urandom_range(0, 1) ? 48'h7FFF_FFFF_FFFF - $urandom_range(0, 5)
                                     : 48'h8000_0000_0000 + $urandom_range(0, 5);
         default: v = 48'({$urandom, $urandom} >> $urandom_range(0, 47));
      endcase
      return v;
   endfunction

   task automatic directed_set();
      send_request(CMD_TICKS_TO_SAMPLES, 48'd0);
      send_request(CMD_TICKS_TO_SAMPLES, 48'd1);
      send_request(CMD_TICKS_TO_SAMPLES, 48'hFFFF_FFFF_FFFF);
      send_request(CMD_TICKS_TO_SAMPLES, 48'h7FFF_FFFF_FFFF);
      send_request(CMD_TICKS_TO_SAMPLES, 48'h8000_0000_0000);
      send_request(CMD_SAMPLES_TO_TICKS, 48'd0);
      send_request(CMD_SAMPLES_TO_TICKS, 48'd25);
      send_request(CMD_SAMPLES_TO_TICKS, 48'd12);
      send_request(CMD_SAMPLES_TO_TICKS, 48'hFFFF_FFFF_FFFF);
      send_request(CMD_SAMPLES_TO_TICKS, 48'h7FFF_FFFF_FFFF);
      send_request(CMD_SAMPLES_TO_TICKS, 48'h8000_0000_0000);
   endtask

   initial begin
      logic [19:0] t, r;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed_set();
      drain();
      // exact halves: one tick is 62.5 samples
      write_csr(CSR_TEMPO, 20'd1);
      write_csr(CSR_RATE, 20'd1);
      send_request(CMD_TICKS_TO_SAMPLES, 48'd1);
      send_request(CMD_TICKS_TO_SAMPLES, 48'hFFFF_FFFF_FFFF);
      send_request(CMD_TICKS_TO_SAMPLES, 48'd3);
      send_request(CMD_TICKS_TO_SAMPLES, 48'h7FFF_FFFF_FFFF);
      send_request(CMD_SAMPLES_TO_TICKS, 48'd125);
      drain();
      write_csr(CSR_TEMPO, 20'd0);
      send_request(CMD_TICKS_TO_SAMPLES, 48'd100);
      send_request(CMD_SAMPLES_TO_TICKS, 48'hFFFF_FFFF_FFF0);
      drain();
      write_csr(CSR_TEMPO, 20'd120000);
      write_csr(CSR_RATE, 20'd0);
      send_request(CMD_TICKS_TO_SAMPLES, 48'd100);
      send_request(CMD_SAMPLES_TO_TICKS, 48'd100);
      drain();
      for (int ph = 0; ph < 14; ph++) begin
         case (ph)
            0: begin t = 20'd1000000; r = 20'd768000; end
            1: begin t = 20'hFFFFF;   r = 20'hFFFFF;  end
            2: begin t = 20'd1;       r = 20'd768000; end
            3: begin t = 20'd1000000; r = 20'd1;      end
            default: begin
               t = $urandom_range(0, 7) == 0 ? 20'($urandom)
                                             : 20'($urandom_range(20000, 300000));
               case ($urandom_range(0, 5))
                  0: r = 20'd44100;
                  1: r = 20'd48000;
                  2: r = 20'd96000;
                  3: r = 20'd192000;
                  4: r = 20'($urandom);
                  default: r = 20'($urandom_range(8000, 768000));
               endcase
               if ($urandom_range(0, 19) == 0) t = 0;
            end
         endcase
         if (ph == 13) idling = 0;
         write_csr(CSR_TEMPO, t);
         write_csr(CSR_RATE, r);
         repeat (122) send_request(command_type'($urandom_range(0, 1)), random_value());
         drain();
      end
      $display("tb: %0d conversions over %0d register writes, both directions,", sent, cfg_count);
      $display("tb: %0d responses checked incl. zero, half, saturation cases", sb.checked);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: %0d mismatches", sb.errors);
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb: timeout");
      $display("tb: errors");
      $finish;
   end

endmodule
